### src/assert_macros.svh
// Assertion macros shared by the RTL files of the aim gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define QEAG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define QEAG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/qeag_pkg.sv
// Package of the aim gate: widths, constants, word types and the arctangent table.
package qeag_pkg;

  localparam int unsigned IN_DATA_W        = 136;
  localparam int unsigned OUT_DATA_W       = 56;
  localparam int unsigned TERM_W           = 40;
  localparam int unsigned Z_W              = 35;
  localparam int unsigned SQ_STEPS         = 29;
  localparam int unsigned Q_DEPTH          = 4;
  localparam int unsigned FIRE_BIT_DEF     = 0;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic [15:0]              GAIN_RST  = 16'd2621;
  localparam logic signed [TERM_W-1:0] ONE_Q28   = 40'sd268435456;
  localparam logic signed [Z_W-1:0]    PI_Q30    = 35'sd3373259426;
  localparam logic signed [15:0]       ANGLE_MAX = 16'sd25736;
  localparam logic signed [15:0]       HALF_PI   = 16'sd12868;

  // Operands of the first and third angle units plus the middle sine term
  typedef struct packed {
    logic signed [TERM_W-1:0] a1_y;
    logic signed [TERM_W-1:0] a1_x;
    logic signed [TERM_W-1:0] a3_y;
    logic signed [TERM_W-1:0] a3_x;
    logic signed [28:0]       s;
  } terms_t;

  // Fields that ride alongside the angle pipeline
  typedef struct packed {
    logic signed [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [31:0]        tol;
    logic [7:0]         notice;
    logic               sat_pos;
    logic               sat_neg;
  } side_t;

  typedef struct packed {
    terms_t terms;
    side_t  side;
  } item_t;

  // atan(2^-i) in radians scaled by 2^30
  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### src/qeag_front.sv
// Front end: unpack a word, form the quaternion products and classify the middle sine.
module qeag_front (
  input  logic [qeag_pkg::IN_DATA_W-1:0] data_i,
  input  logic [15:0]                    gain_i,
  output qeag_pkg::item_t                item_o
);

  logic signed [15:0] w, x, y, z;
  logic [15:0] dist_m;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  logic signed [qeag_pkg::TERM_W-1:0] s_full;

  // Unpack quaternion and distance
  assign w      = data_i[15:0];
  assign x      = data_i[31:16];
  assign y      = data_i[47:32];
  assign z      = data_i[63:48];
  assign dist_m = data_i[127:112];

  // Form the products
  assign p_wx = w * x;
  assign p_yz = y * z;
  assign p_xx = x * x;
  assign p_yy = y * y;
  assign p_wz = w * z;
  assign p_xy = x * y;
  assign p_zz = z * z;
  assign p_wy = w * y;
  assign p_zx = z * x;

  assign s_full = (qeag_pkg::TERM_W'(p_wy) - qeag_pkg::TERM_W'(p_zx)) <<< 1;

  // Build the queue word and flag a saturated middle sine
  always_comb begin
    item_o.terms.a1_y   = (qeag_pkg::TERM_W'(p_wx) + qeag_pkg::TERM_W'(p_yz)) <<< 1;
    item_o.terms.a1_x   = qeag_pkg::ONE_Q28
                        - ((qeag_pkg::TERM_W'(p_xx) + qeag_pkg::TERM_W'(p_yy)) <<< 1);
    item_o.terms.a3_y   = (qeag_pkg::TERM_W'(p_wz) + qeag_pkg::TERM_W'(p_xy)) <<< 1;
    item_o.terms.a3_x   = qeag_pkg::ONE_Q28
                        - ((qeag_pkg::TERM_W'(p_yy) + qeag_pkg::TERM_W'(p_zz)) <<< 1);
    item_o.terms.s      = s_full[28:0];
    item_o.side.t1      = data_i[79:64];
    item_o.side.t2      = data_i[95:80];
    item_o.side.t3      = data_i[111:96];
    item_o.side.tol     = gain_i * dist_m;
    item_o.side.notice  = data_i[135:128];
    item_o.side.sat_pos = s_full >= qeag_pkg::ONE_Q28;
    item_o.side.sat_neg = s_full <= -qeag_pkg::ONE_Q28;
  end

endmodule

### src/qeag_queue.sv
// Short queue that decouples the front end from the angle pipeline.
`include "assert_macros.svh"
module qeag_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  qeag_pkg::item_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output qeag_pkg::item_t rd_data_o
);

  localparam int unsigned DEPTH = qeag_pkg::Q_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qeag_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic wr_fire, rd_fire;

  assign wr_ready_o = count_q != CNT_W'(DEPTH);
  assign rd_valid_o = count_q != '0;
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem[rd_ptr_q];

  // Advance pointers with wrap and track the fill
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_fire && !rd_fire) begin
      count_d = count_q + 1'b1;
    end else if (rd_fire && !wr_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  `QEAG_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "queue overfilled")
  `QEAG_ASSERT(a_fill_step, clk_i, rst_ni, wr_fire && !rd_fire |=> count_q == $past(count_q) + 1'b1, "fill count did not rise")

endmodule

### src/qeag_cordic.sv
// Pipelined vectoring CORDIC lane giving atan2(y, x) in Q2.13, one stage per step.
module qeag_cordic #(
  parameter int unsigned STEPS = qeag_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [qeag_pkg::TERM_W-1:0] x_i,
  input  logic signed [qeag_pkg::TERM_W-1:0] y_i,
  output logic signed [15:0]                 angle_o
);

  localparam int unsigned TW = qeag_pkg::TERM_W;
  localparam int unsigned ZW = qeag_pkg::Z_W;
  localparam int unsigned RW = ZW - 17;

  logic signed [TW-1:0] x_q [STEPS+1];
  logic signed [TW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic signed [ZW-1:0] z_rnd;
  logic signed [RW-1:0] r;
  logic signed [15:0]   angle_d, angle_q;

  // Reduce to the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? qeag_pkg::PI_Q30 : -qeag_pkg::PI_Q30;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  // Rotate towards the x axis, one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] TAB = $signed(ZW'(qeag_pkg::atan_entry(i)));
    logic signed [TW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + TAB;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - TAB;
        end
      end
    end
  end

  // Round to Q2.13 and saturate
  assign z_rnd = z_q[STEPS] + ZW'(65536);
  assign r     = RW'(z_rnd >>> 17);

  always_comb begin
    if (zero_q[STEPS]) begin
      angle_d = '0;
    end else if (r > RW'(qeag_pkg::ANGLE_MAX)) begin
      angle_d = qeag_pkg::ANGLE_MAX;
    end else if (r < -RW'(qeag_pkg::ANGLE_MAX)) begin
      angle_d = -qeag_pkg::ANGLE_MAX;
    end else begin
      angle_d = r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

### src/qeag_back.sv
// Back end: square root for the middle cosine, three angle lanes and the fire test.
`include "assert_macros.svh"
module qeag_back #(
  parameter int unsigned CORDIC_STEPS = qeag_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned FIRE_BIT     = qeag_pkg::FIRE_BIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qeag_pkg::item_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_notice_o,
  output logic               out_fire_o,
  output logic signed [15:0] out_a1_o,
  output logic signed [14:0] out_a2_o,
  output logic signed [15:0] out_a3_o
);

  localparam int unsigned SQ       = qeag_pkg::SQ_STEPS;
  localparam int unsigned TW       = qeag_pkg::TERM_W;
  localparam int unsigned SIDE_LAT = 1 + SQ + CORDIC_STEPS + 2;
  localparam int unsigned PIPE_LAT = SIDE_LAT + 1;

  logic adv;
  logic [PIPE_LAT-1:0] vld_q;

  logic signed [57:0] s_sq;
  logic [57:0]        c2_full;
  logic [56:0]        c2_q;
  logic [56:0]        n_q [1:SQ];
  logic [57:0]        r_q [1:SQ];
  qeag_pkg::terms_t   term_q [SQ+1];
  qeag_pkg::side_t    side_q [SIDE_LAT];
  qeag_pkg::side_t    sd;

  logic signed [TW-1:0] sqrt_x;
  logic signed [15:0]   a1, a2_raw, a3, a2;
  logic [16:0]          e1, e2, e3;
  logic signed [16:0]   d1, d2, d3;
  logic                 fire;
  logic [7:0]           notice;

  logic [7:0]         notice_q;
  logic               fire_q;
  logic signed [15:0] a1_q, a3_q;
  logic signed [14:0] a2_q;

  // Advance the whole pipeline unless the result word is stuck
  assign adv        = !vld_q[PIPE_LAT-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // Middle cosine squared: 1 - s*s in Q.56
  assign s_sq    = in_data_i.terms.s * in_data_i.terms.s;
  assign c2_full = (58'd1 << 56) - $unsigned(s_sq);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q      <= c2_full[56:0];
      term_q[0] <= in_data_i.terms;
      side_q[0] <= in_data_i.side;
    end
  end

  // Delay the operands and side fields
  for (genvar k = 1; k <= SQ; k++) begin : g_term_dly
    always_ff @(posedge clk_i) begin
      if (adv) begin
        term_q[k] <= term_q[k-1];
      end
    end
  end

  for (genvar k = 1; k < SIDE_LAT; k++) begin : g_side_dly
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Floor square root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [57:0] BIT = 58'd1 << (56 - 2 * k);
    logic [56:0] n_in;
    logic [57:0] r_in, trial;
    if (k == 0) begin : g_first
      assign n_in = c2_q;
      assign r_in = '0;
    end else begin : g_rest
      assign n_in = n_q[k];
      assign r_in = r_q[k];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if ({1'b0, n_in} >= trial) begin
          n_q[k+1] <= n_in - trial[56:0];
          r_q[k+1] <= (r_in >> 1) + BIT;
        end else begin
          n_q[k+1] <= n_in;
          r_q[k+1] <= r_in >> 1;
        end
      end
    end
  end

  assign sqrt_x = TW'({1'b0, r_q[SQ][28:0]});

  // Three angle lanes
  qeag_cordic #(.STEPS(CORDIC_STEPS)) u_lane1 (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x_i     (term_q[SQ].a1_x),
    .y_i     (term_q[SQ].a1_y),
    .angle_o (a1)
  );

  qeag_cordic #(.STEPS(CORDIC_STEPS)) u_lane2 (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x_i     (sqrt_x),
    .y_i     (TW'(term_q[SQ].s)),
    .angle_o (a2_raw)
  );

  qeag_cordic #(.STEPS(CORDIC_STEPS)) u_lane3 (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x_i     (term_q[SQ].a3_x),
    .y_i     (term_q[SQ].a3_y),
    .angle_o (a3)
  );

  assign sd = side_q[SIDE_LAT-1];

  // Saturate the middle angle and test each error against the tolerance
  always_comb begin
    if (sd.sat_pos || a2_raw > qeag_pkg::HALF_PI) begin
      a2 = qeag_pkg::HALF_PI;
    end else if (sd.sat_neg || a2_raw < -qeag_pkg::HALF_PI) begin
      a2 = -qeag_pkg::HALF_PI;
    end else begin
      a2 = a2_raw;
    end
    d1 = 17'(a1) - 17'(sd.t1);
    d2 = 17'(a2) - 17'(sd.t2);
    d3 = 17'(a3) - 17'(sd.t3);
    e1 = (d1 < 0) ? 17'(-d1) : 17'(d1);
    e2 = (d2 < 0) ? 17'(-d2) : 17'(d2);
    e3 = (d3 < 0) ? 17'(-d3) : 17'(d3);
    fire = ((32'(e1) << 11) < sd.tol) && ((32'(e2) << 11) < sd.tol)
        && ((32'(e3) << 11) < sd.tol);
    notice = sd.notice;
    notice[FIRE_BIT] = fire;
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      notice_q <= notice;
      fire_q   <= fire;
      a1_q     <= a1;
      a2_q     <= a2[14:0];
      a3_q     <= a3;
    end
  end

  assign out_valid_o  = vld_q[PIPE_LAT-1];
  assign out_notice_o = notice_q;
  assign out_fire_o   = fire_q;
  assign out_a1_o     = a1_q;
  assign out_a2_o     = a2_q;
  assign out_a3_o     = a3_q;

  `QEAG_ASSERT(a_fire_mirror, clk_i, rst_ni, out_valid_o |-> out_notice_o[FIRE_BIT] == out_fire_o, "notice fire bit differs from fire")
  `QEAG_ASSERT(a_mid_range, clk_i, rst_ni, out_valid_o |-> (out_a2_o <= 15'sd12868 && out_a2_o >= -15'sd12868), "middle angle out of range")

endmodule

### src/quaternion_euler_aim_gate.sv
// Top level of the quaternion to Euler angle aim gate.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: quaternion, targets, distance, notice
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: notice and angles, tuser: fire
//  cfg       in   cfg_we_i                      cfg_wdata_i: tolerance gain
//
// One word is accepted per cycle while the queue has room; each word passes from acceptance
// to result through one queue slot, the cosine register, the 29 stage square root, the
// CORDIC_STEPS + 2 stage angle lanes and the result register.
// A four word queue sits between front and back, so the input keeps flowing for up to
// four words while a result waits. A stalled result freezes the back pipeline in place.
// Reset clears control state and loads the gain with its default; no clearing pass.
module quaternion_euler_aim_gate #(
  parameter int unsigned FIRE_BIT     = qeag_pkg::FIRE_BIT_DEF,
  parameter int unsigned CORDIC_STEPS = qeag_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, target_first, target_second, target_third,
  // distance, notice_in
  input  logic [qeag_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // notice_out, angle_first, angle_second, angle_third, one zero pad bit
  output logic [qeag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // fire
  output logic                            m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i
);

  logic [15:0] gain_q;
  qeag_pkg::item_t fr_item, q_item;
  logic q_valid, q_ready;
  logic [7:0] notice_out;
  logic signed [15:0] a1, a3;
  logic signed [14:0] a2;

  // Hold the tolerance gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= qeag_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  qeag_front u_front (
    .data_i (s_axis_tdata),
    .gain_i (gain_q),
    .item_o (fr_item)
  );

  qeag_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_data_i  (fr_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_item)
  );

  qeag_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FIRE_BIT     (FIRE_BIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_data_i    (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_notice_o (notice_out),
    .out_fire_o   (m_axis_tuser),
    .out_a1_o     (a1),
    .out_a2_o     (a2),
    .out_a3_o     (a3)
  );

  // Pack the result word
  assign m_axis_tdata = {1'b0, a3, a2, a1, notice_out};

endmodule

### test/aim_gate_checker.sv
// Checker of the aim gate: watches both channels, predicts each result and compares it.
`timescale 1ns / 100ps

module aim_gate_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [qeag_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [qeag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i,
  output int                              fail_count,
  output int                              pending_count
);

  localparam int unsigned FIRE_BIT = qeag_pkg::FIRE_BIT_DEF;
  localparam int unsigned STEPS    = qeag_pkg::CORDIC_STEPS_DEF;
  localparam longint      PI_Q30L  = 64'sd3373259426;

  typedef struct {
    logic [7:0]         notice;
    logic               fire;
    logic signed [15:0] a1;
    logic signed [14:0] a2;
    logic signed [15:0] a3;
  } aim_result_t;

  aim_result_t     expected_q[$];
  logic     [15:0] gain;

  longint atan_lut [24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  function automatic longint limit(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // vectoring rotation, floor shifts, accumulator in 2^-30 rad
  function automatic longint angle_of(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30L : -PI_Q30L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z += atan_lut[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z -= atan_lut[i];
      end
    end
    return limit((z + (64'sd1 <<< 16)) >>> 17, 25736);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint pitch_of(longint s);
    if (s >= (64'sd1 <<< 28)) return 12868;
    if (s <= -(64'sd1 <<< 28)) return -12868;
    return limit(angle_of(s, root_floor((64'd1 << 56) - longint'(s * s))), 12868);
  endfunction

  function automatic bit on_target(longint a, longint t, longint tol);
    longint d;
    d = a - t;
    if (d < 0) d = -d;
    return d * 2048 < tol;
  endfunction

  function automatic aim_result_t predict_aim(logic [qeag_pkg::IN_DATA_W-1:0] d);
    aim_result_t r;
    longint w, x, y, z, t1, t2, t3, tol, a1, a2, a3;
    w  = longint'($signed(d[15:0]));
    x  = longint'($signed(d[31:16]));
    y  = longint'($signed(d[47:32]));
    z  = longint'($signed(d[63:48]));
    t1 = longint'($signed(d[79:64]));
    t2 = longint'($signed(d[95:80]));
    t3 = longint'($signed(d[111:96]));
    tol = longint'(gain) * longint'(d[127:112]);
    a1 = angle_of(2 * (w * x + y * z), (64'sd1 <<< 28) - 2 * (x * x + y * y));
    a2 = pitch_of(2 * (w * y - z * x));
    a3 = angle_of(2 * (w * z + x * y), (64'sd1 <<< 28) - 2 * (y * y + z * z));
    r.fire = on_target(a1, t1, tol) && on_target(a2, t2, tol) && on_target(a3, t3, tol);
    r.notice = d[135:128];
    r.notice[FIRE_BIT] = r.fire;
    r.a1 = a1[15:0];
    r.a2 = a2[14:0];
    r.a3 = a3[15:0];
    return r;
  endfunction

  assign pending_count = expected_q.size();

  // track the gain, predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    aim_result_t e;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      gain <= qeag_pkg::GAIN_RST;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(predict_aim(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no prediction waiting");
          errs++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          if (m_axis_tdata[7:0] !== e.notice) begin
            $error("notice_out expected %0h actual %0h", e.notice, m_axis_tdata[7:0]);
            errs++;
          end
          if (m_axis_tuser !== e.fire) begin
            $error("fire expected %0d actual %0d", e.fire, m_axis_tuser);
            errs++;
          end
          if (m_axis_tdata[23:8] !== e.a1) begin
            $error("angle_first expected %0d actual %0d", e.a1,
                   $signed(m_axis_tdata[23:8]));
            errs++;
          end
          if (m_axis_tdata[38:24] !== e.a2) begin
            $error("angle_second expected %0d actual %0d", e.a2,
                   $signed(m_axis_tdata[38:24]));
            errs++;
          end
          if (m_axis_tdata[54:39] !== e.a3) begin
            $error("angle_third expected %0d actual %0d", e.a3,
                   $signed(m_axis_tdata[54:39]));
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (cfg_we_i) gain <= cfg_wdata_i;
    end
  end

endmodule

### test/testbench.sv
// Top of the aim gate test: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [qeag_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [qeag_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            cfg_we_i = 1'b0;
  logic [15:0]                     cfg_wdata_i = '0;
  int                              fail_count;
  int                              pending_count;
  int                              idle_cycles = 0;
  int                              rx_wait = 0;
  bit                              rx_stall_on = 1'b1;

  always #5 clk_i = ~clk_i;

  quaternion_euler_aim_gate dut (.*);

  aim_gate_checker checker_i (.*);

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quaternion_euler_aim_gate test failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: ready for one cycle, then a random stall, toggled off during some stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!rx_stall_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_wait != 0) begin
      m_axis_tready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_wait <= gap_len();
    end
  end

  function automatic logic [15:0] rand_comp(bit unit_like);
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return unit_like ? 16'($urandom_range(0, 32768) - 16384) : 16'($urandom());
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // send one word, holding it until accepted; drop valid only ahead of a gap
  task automatic send_word(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] t1, logic [15:0] t2, logic [15:0] t3,
                           logic [15:0] dist_m, logic [7:0] notice, bit use_gaps);
    int g;
    g = use_gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata  <= {notice, dist_m, t3, t2, t1, z, y, x, w};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // random word; the targets mostly track a plausible attitude so fire is hit
  task automatic send_random(bit use_gaps);
    logic [15:0] t1, t2, t3;
    bit near;
    near = ($urandom_range(0, 2) != 0);
    t1 = near ? 16'($urandom_range(0, 51472) - 25736) : 16'($urandom());
    t2 = near ? 16'($urandom_range(0, 25736) - 12868) : 16'($urandom());
    t3 = near ? 16'($urandom_range(0, 51472) - 25736) : 16'($urandom());
    if (near && $urandom_range(0, 1)) begin
      t1 = 16'($urandom_range(0, 400) - 200);
      t2 = 16'($urandom_range(0, 400) - 200);
      t3 = 16'($urandom_range(0, 400) - 200);
      send_word(16'sd16384 - 16'($urandom_range(0, 60)), 16'($urandom_range(0, 200) - 100),
                16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 200) - 100),
                t1, t2, t3, 16'($urandom()), 8'($urandom()), use_gaps);
    end else begin
      send_word(rand_comp(1), rand_comp(0), rand_comp(1), rand_comp(1), t1, t2, t3,
                16'($urandom()), 8'($urandom()), use_gaps);
    end
  endtask

  // drop valid, drain, let the pipeline settle, then load a new gain
  task automatic set_gain(logic [15:0] g);
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= g;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [15:0] gains [5];
    gains = '{16'd65535, 16'd0, 16'd1, 16'd2621, 16'd40000};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, extremes, poles, degenerate terms
    send_word(16'sd16384, 0, 0, 0, 0, 0, 0, 16'hFFFF, 8'hFE, 0);
    send_word(16'sd16384, 0, 0, 0, 0, 0, 0, 16'h0000, 8'hFF, 0);
    send_word(0, 16'sd16384, 0, 0, 16'sd25736, 0, 0, 16'h0100, 8'h00, 0);
    send_word(0, 0, 16'sd16384, 0, 0, 0, 16'sd25736, 16'hFFFF, 8'h55, 0);
    send_word(0, 0, 0, 16'sd16384, 0, 0, 16'sd25736, 16'hFFFF, 8'hAA, 0);
    send_word(0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 8'h01, 0);
    send_word(16'sd11585, 0, 16'sd11585, 0, 0, 16'sd12868, 0, 16'hFFFF, 8'h00, 0);
    send_word(16'sd11585, 0, -16'sd11585, 0, 0, -16'sd12868, 0, 16'hFFFF, 8'h00, 0);
    send_word(16'sd16384, 0, 16'sd16384, 0, 0, 16'sd12868, 0, 16'h1234, 8'h00, 0);
    send_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
              16'hFFFF, 8'hFF, 0);
    send_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h0001, 8'h00, 0);
    send_word(-16'sd16384, 0, 0, 0, 16'sd100, 16'sd100, 16'sd100, 16'h0001, 8'h00, 0);
    send_word(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0, 0, 0, 16'hFFFF, 8'h80, 0);
    send_word(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 0, 0, 0, 16'h8000, 8'h7F, 0);

    // random phases, one per gain setting, the receiver sometimes never stalling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_gain(gains[ph - 1]);
      rx_stall_on = (ph != 2);
      for (int n = 0; n < 290; n++) send_random(ph != 4);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("quaternion_euler_aim_gate test passed");
    else
      $display("quaternion_euler_aim_gate test failed");
    $finish;
  end

endmodule
